[hw/rtl/cpp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_pkg
// shared types and constants of the camera perspective projection pipeline
// ----------------------------------------------------------------------------
package cpp_pkg;

  // camera-space word widths
  localparam int D_W   = 33;  // translated coordinate
  localparam int R1_W  = 36;  // after yaw rotation
  localparam int R2_W  = 39;  // after pitch rotation
  localparam int FOV_W = 24;
  localparam int QB    = 21;  // quotient bits kept by the divider
  localparam int RND   = 8192;

  typedef enum logic [2:0] {
    CFG_CAM_X     = 3'd0,
    CFG_CAM_Y     = 3'd1,
    CFG_CAM_Z     = 3'd2,
    CFG_COS_YAW   = 3'd3,
    CFG_SIN_YAW   = 3'd4,
    CFG_COS_PITCH = 3'd5,
    CFG_SIN_PITCH = 3'd6,
    CFG_INV_FOV   = 3'd7
  } cpp_cfg_idx_t;

  typedef struct packed {
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [15:0]        attribute;
  } cpp_in_t;

  typedef struct packed {
    logic               visible;
    logic signed [15:0] screen_x;
    logic signed [15:0] screen_y;
    logic [30:0]        depth;
    logic [15:0]        attribute_out;
  } cpp_out_t;

  typedef struct packed {
    logic signed [31:0] cam_x;
    logic signed [31:0] cam_y;
    logic signed [31:0] cam_z;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [15:0] cos_pitch;
    logic signed [15:0] sin_pitch;
    logic [FOV_W-1:0]   inv_fov;
  } cpp_cfg_t;

  typedef struct packed {
    logic                   visible;
    logic signed [R1_W-1:0] x1;
    logic signed [R2_W-1:0] y2;
    logic signed [R2_W-1:0] z2;
    logic [15:0]            attr;
  } cpp_rot_t;

  typedef struct packed {
    logic        visible;
    logic        x_neg;
    logic        y_neg;
    logic        x_sat;
    logic        y_sat;
    logic [30:0] depth;
    logic [15:0] attr;
  } cpp_side_t;

endpackage
`default_nettype wire

[hw/rtl/cpp_rotate.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_rotate
// translation, yaw and pitch rotation in five register stages
// ----------------------------------------------------------------------------
module cpp_rotate (
  input  wire                logic clk,
  input  wire                logic rst_n,
  input  wire                logic en,
  input  wire                logic in_valid,
  input  wire cpp_pkg::cpp_in_t  in_data,
  input  wire cpp_pkg::cpp_cfg_t cfg,
  output logic               rot_valid,
  output cpp_pkg::cpp_rot_t  rot
);
  import cpp_pkg::*;

  localparam int PY_W = D_W + 16;      // yaw product
  localparam int SY_W = PY_W + 1;
  localparam int PP_W = R1_W + 16;     // widest pitch product
  localparam int SP_W = PP_W + 1;

  logic [4:0] vld_r;

  // stage 1: translation
  logic signed [D_W-1:0] dx_r, dy_r, dz_r;
  logic [15:0]           a1_r;
  // stage 2: yaw products
  logic signed [PY_W-1:0] pxc_r, pzs_r, pzc_r, pxs_r;
  logic signed [D_W-1:0]  dy2_r;
  logic [15:0]            a2_r;
  // stage 3: yaw rounding
  logic signed [R1_W-1:0] x1_r, z1_r;
  logic signed [D_W-1:0]  dy3_r;
  logic [15:0]            a3_r;
  // stage 4: pitch products
  logic signed [PP_W-1:0] pdc_r, pzs2_r, pds_r, pzc2_r;
  logic signed [R1_W-1:0] x14_r;
  logic [15:0]            a4_r;
  // stage 5: pitch rounding
  logic signed [R2_W-1:0] y2_r, z2_r;
  logic signed [R1_W-1:0] x15_r;
  logic [15:0]            a5_r;

  logic signed [SY_W-1:0] sx_w, sz_w, rx_w, rz_w;
  logic signed [SP_W-1:0] sy2_w, sz2_w, ry_w, rz2_w;

  always_comb begin
    sx_w  = SY_W'(pxc_r) + SY_W'(pzs_r) + SY_W'(RND);
    sz_w  = SY_W'(pzc_r) - SY_W'(pxs_r) + SY_W'(RND);
    rx_w  = sx_w >>> 14;
    rz_w  = sz_w >>> 14;
    sy2_w = SP_W'(pdc_r) - SP_W'(pzs2_r) + SP_W'(RND);
    sz2_w = SP_W'(pds_r) + SP_W'(pzc2_r) + SP_W'(RND);
    ry_w  = sy2_w >>> 14;
    rz2_w = sz2_w >>> 14;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[3:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r   <= D_W'(in_data.point_x) - D_W'(cfg.cam_x);
      dy_r   <= D_W'(in_data.point_y) - D_W'(cfg.cam_y);
      dz_r   <= D_W'(in_data.point_z) - D_W'(cfg.cam_z);
      a1_r   <= in_data.attribute;

      pxc_r  <= PY_W'(dx_r) * PY_W'(cfg.cos_yaw);
      pzs_r  <= PY_W'(dz_r) * PY_W'(cfg.sin_yaw);
      pzc_r  <= PY_W'(dz_r) * PY_W'(cfg.cos_yaw);
      pxs_r  <= PY_W'(dx_r) * PY_W'(cfg.sin_yaw);
      dy2_r  <= dy_r;
      a2_r   <= a1_r;

      x1_r   <= rx_w[R1_W-1:0];
      z1_r   <= rz_w[R1_W-1:0];
      dy3_r  <= dy2_r;
      a3_r   <= a2_r;

      pdc_r  <= PP_W'(dy3_r) * PP_W'(cfg.cos_pitch);
      pzs2_r <= PP_W'(z1_r) * PP_W'(cfg.sin_pitch);
      pds_r  <= PP_W'(dy3_r) * PP_W'(cfg.sin_pitch);
      pzc2_r <= PP_W'(z1_r) * PP_W'(cfg.cos_pitch);
      x14_r  <= x1_r;
      a4_r   <= a3_r;

      y2_r   <= ry_w[R2_W-1:0];
      z2_r   <= rz2_w[R2_W-1:0];
      x15_r  <= x14_r;
      a5_r   <= a4_r;
    end
  end

  assign rot_valid   = vld_r[4];
  assign rot.visible = (z2_r > 0);
  assign rot.x1      = x15_r;
  assign rot.y2      = y2_r;
  assign rot.z2      = z2_r;
  assign rot.attr    = a5_r;

endmodule
`default_nettype wire

[hw/rtl/cpp_divide.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_divide
// perspective divide of both screen axes: denominator product, overflow check
// and a restoring divider that resolves three quotient bits per stage
// ----------------------------------------------------------------------------
module cpp_divide #(
  parameter int SCREEN_WIDTH = 400
) (
  input  wire                   logic clk,
  input  wire                   logic rst_n,
  input  wire                   logic en,
  input  wire                   logic rot_valid,
  input  wire cpp_pkg::cpp_rot_t rot,
  input  wire                   logic [cpp_pkg::FOV_W-1:0] inv_fov,
  output logic                  div_valid,
  output logic [cpp_pkg::QB-1:0] qx,
  output logic [cpp_pkg::QB-1:0] qy,
  output cpp_pkg::cpp_side_t    side
);
  import cpp_pkg::*;

  localparam int SW_W  = $clog2(SCREEN_WIDTH + 1);
  localparam int MAG_W = R2_W;
  localparam int NUM_W = MAG_W + SW_W + 16;
  localparam int DEN_W = (R2_W - 1) + FOV_W;
  localparam int REM_W = DEN_W + QB;
  localparam int SPS   = 3;
  localparam int NST   = (QB + SPS - 1) / SPS;

  // denominator / numerator stage
  logic                 pv_r;
  logic [DEN_W-1:0]     pden_r;
  logic [NUM_W-1:0]     pnx_r, pny_r;
  cpp_side_t            pside_r;

  logic signed [MAG_W-1:0] xs_w;
  logic [MAG_W-1:0]        magx_w, magy_w;
  logic [FOV_W-1:0]        fov_w;
  logic [30:0]             depth_w;

  always_comb begin
    xs_w    = MAG_W'(rot.x1);
    magx_w  = xs_w[MAG_W-1] ? MAG_W'(-xs_w) : MAG_W'(xs_w);
    magy_w  = rot.y2[R2_W-1] ? MAG_W'(-rot.y2) : MAG_W'(rot.y2);
    fov_w   = (inv_fov == '0) ? FOV_W'(1) : inv_fov;
    depth_w = (rot.z2[R2_W-1:31] != '0) ? 31'h7FFF_FFFF : rot.z2[30:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (en) begin
      pv_r <= rot_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pden_r          <= DEN_W'(rot.z2[R2_W-2:0]) * DEN_W'(fov_w);
      pnx_r           <= {(MAG_W + SW_W)'(magx_w) * (MAG_W + SW_W)'(SCREEN_WIDTH), 16'd0};
      pny_r           <= {(MAG_W + SW_W)'(magy_w) * (MAG_W + SW_W)'(SCREEN_WIDTH), 16'd0};
      pside_r.visible <= rot.visible;
      pside_r.x_neg   <= xs_w[MAG_W-1];
      pside_r.y_neg   <= rot.y2[R2_W-1];
      pside_r.x_sat   <= 1'b0;
      pside_r.y_sat   <= 1'b0;
      pside_r.depth   <= depth_w;
      pside_r.attr    <= rot.attr;
    end
  end

  // divider pipeline, index 0 is the overflow check result
  logic             vld_r  [NST+1];
  logic [DEN_W-1:0] den_r  [NST+1];
  logic [REM_W-1:0] remx_r [NST+1];
  logic [REM_W-1:0] remy_r [NST+1];
  logic [QB-1:0]    qx_r   [NST+1];
  logic [QB-1:0]    qy_r   [NST+1];
  cpp_side_t        side_r [NST+1];

  // quotient that would not fit in QB bits saturates anyway
  logic [REM_W-1:0] dtop_w;
  cpp_side_t        side0_w;
  assign dtop_w = {pden_r, {QB{1'b0}}};

  always_comb begin
    side0_w       = pside_r;
    side0_w.x_sat = REM_W'(pnx_r) >= dtop_w;
    side0_w.y_sat = REM_W'(pny_r) >= dtop_w;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0]        <= pden_r;
      remx_r[0]       <= REM_W'(pnx_r);
      remy_r[0]       <= REM_W'(pny_r);
      qx_r[0]         <= '0;
      qy_r[0]         <= '0;
      side_r[0]       <= side0_w;
    end
  end

  for (genvar g = 0; g < NST; g++) begin : g_step
    logic [REM_W-1:0] rx_nxt, ry_nxt;
    logic [QB-1:0]    qx_nxt, qy_nxt;

    always_comb begin
      logic [REM_W-1:0] dsh;
      dsh    = '0;
      rx_nxt = remx_r[g];
      ry_nxt = remy_r[g];
      qx_nxt = qx_r[g];
      qy_nxt = qy_r[g];
      for (int j = 0; j < SPS; j++) begin
        if (g * SPS + j < QB) begin
          dsh = REM_W'(den_r[g]) << (QB - 1 - g * SPS - j);
          if (rx_nxt >= dsh) begin
            rx_nxt = rx_nxt - dsh;
            qx_nxt[QB-1-g*SPS-j] = 1'b1;
          end
          if (ry_nxt >= dsh) begin
            ry_nxt = ry_nxt - dsh;
            qy_nxt[QB-1-g*SPS-j] = 1'b1;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[g+1] <= 1'b0;
      end else if (en) begin
        vld_r[g+1] <= vld_r[g];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        den_r[g+1]  <= den_r[g];
        remx_r[g+1] <= rx_nxt;
        remy_r[g+1] <= ry_nxt;
        qx_r[g+1]   <= qx_nxt;
        qy_r[g+1]   <= qy_nxt;
        side_r[g+1] <= side_r[g];
      end
    end
  end

  assign div_valid = vld_r[NST];
  assign qx        = qx_r[NST];
  assign qy        = qy_r[NST];
  assign side      = side_r[NST];

endmodule
`default_nettype wire

[hw/rtl/camera_perspective_projection.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// camera_perspective_projection
// projects a world point per cycle, unless stalled, onto screen via the camera
// ----------------------------------------------------------------------------
// pipeline: 15 register stages between the request port and the result port
// throughput: one request per cycle; the whole pipe moves in one step and
//   freezes only while a finished result waits under out_stall
// reset: synchronous active-low, clears every valid bit and loads the camera
//   registers with their default pose; payload registers are not reset
// ----------------------------------------------------------------------------
module camera_perspective_projection #(
  parameter int SCREEN_WIDTH  = 400,
  parameter int SCREEN_HEIGHT = 400
) (
  input  wire                logic clk,
  input  wire                logic rst_n,
  // request channel
  input  wire                logic in_valid,
  output logic               in_stall,
  input  wire cpp_pkg::cpp_in_t in_data,
  // result channel
  output logic               out_valid,
  input  wire                logic out_stall,
  output cpp_pkg::cpp_out_t  out_data,
  // configuration writes
  input  wire                logic cfg_we,
  input  wire                logic [2:0] cfg_index,
  input  wire                logic [31:0] cfg_data
);
  import cpp_pkg::*;

  localparam int HALF_W = SCREEN_WIDTH / 2;
  localparam int HALF_H = SCREEN_HEIGHT / 2;
  localparam int PIX_W  = QB + 3;
  localparam logic [QB-1:0] LIM = QB'(1 << (QB - 1));

  // camera registers
  cpp_cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.cam_x     <= 32'sd0;
      cfg_r.cam_y     <= 32'sd1966080;
      cfg_r.cam_z     <= -32'sd3932160;
      cfg_r.cos_yaw   <= 16'sd16384;
      cfg_r.sin_yaw   <= 16'sd0;
      cfg_r.cos_pitch <= 16'sd14189;
      cfg_r.sin_pitch <= -16'sd8192;
      cfg_r.inv_fov   <= 24'd65536;
    end else if (cfg_we) begin
      unique case (cpp_cfg_idx_t'(cfg_index))
        CFG_CAM_X:     cfg_r.cam_x     <= cfg_data;
        CFG_CAM_Y:     cfg_r.cam_y     <= cfg_data;
        CFG_CAM_Z:     cfg_r.cam_z     <= cfg_data;
        CFG_COS_YAW:   cfg_r.cos_yaw   <= cfg_data[15:0];
        CFG_SIN_YAW:   cfg_r.sin_yaw   <= cfg_data[15:0];
        CFG_COS_PITCH: cfg_r.cos_pitch <= cfg_data[15:0];
        CFG_SIN_PITCH: cfg_r.sin_pitch <= cfg_data[15:0];
        CFG_INV_FOV:   cfg_r.inv_fov   <= cfg_data[FOV_W-1:0];
        default:       cfg_r           <= cfg_r;
      endcase
    end
  end

  // global advance: the pipe holds only when the output register is full
  // and the consumer is stalling
  logic en;
  assign en       = !out_valid || !out_stall;
  assign in_stall = !en;

  // stages 1 to 5: translate and rotate
  logic     rot_valid;
  cpp_rot_t rot;

  cpp_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .cfg       (cfg_r),
    .rot_valid (rot_valid),
    .rot       (rot)
  );

  // stages 6 to 14: denominator, overflow check, divider
  logic          div_valid;
  logic [QB-1:0] qx, qy;
  cpp_side_t     side;

  cpp_divide #(
    .SCREEN_WIDTH (SCREEN_WIDTH)
  ) u_divide (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .rot_valid (rot_valid),
    .rot       (rot),
    .inv_fov   (cfg_r.inv_fov),
    .div_valid (div_valid),
    .qx        (qx),
    .qy        (qy),
    .side      (side)
  );

  function automatic logic signed [15:0] sat16(input logic signed [PIX_W-1:0] v);
    if (v > PIX_W'(32767)) begin
      return 16'sh7FFF;
    end else if (v < -PIX_W'(32768)) begin
      return -16'sh8000;
    end
    return v[15:0];
  endfunction

  // stage 15: clamp offset, centre on screen, saturate to pixel range
  logic [QB-1:0]          mx_w, my_w;
  logic signed [PIX_W-1:0] ox_w, oy_w, px_w, py_w;
  cpp_out_t               res_w;

  always_comb begin
    mx_w = (side.x_sat || qx > LIM) ? LIM : qx;
    my_w = (side.y_sat || qy > LIM) ? LIM : qy;
    ox_w = side.x_neg ? -PIX_W'(mx_w) : PIX_W'(mx_w);
    oy_w = side.y_neg ? -PIX_W'(my_w) : PIX_W'(my_w);
    px_w = PIX_W'(HALF_W) + ox_w;
    py_w = PIX_W'(HALF_H) - oy_w;
    res_w = '0;
    if (side.visible) begin
      res_w.visible       = 1'b1;
      res_w.screen_x      = sat16(px_w);
      res_w.screen_y      = sat16(py_w);
      res_w.depth         = side.depth;
      res_w.attribute_out = side.attr;
    end
  end

  logic     out_valid_r;
  cpp_out_t out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= div_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= res_w;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[hw/rtl/cpp_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// cpp_checker
// port-level checks of the projection pipeline, bound to the top level
// ----------------------------------------------------------------------------
module cpp_checker (
  input wire               logic clk,
  input wire               logic rst_n,
  input wire               logic in_stall,
  input wire               logic out_valid,
  input wire               logic out_stall,
  input wire cpp_pkg::cpp_out_t out_data
);
  import cpp_pkg::*;

  // a held result stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed under stall");

  // culled points carry an all-zero payload
  a_cull: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.visible |->
      out_data.screen_x == 16'sd0 && out_data.screen_y == 16'sd0 &&
      out_data.depth == 31'd0 && out_data.attribute_out == 16'd0)
    else $error("culled point with non-zero payload");

  // a visible point has positive depth
  a_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.visible |-> out_data.depth != 31'd0)
    else $error("visible point with zero depth");

  // the pipe only backs up when a result is held
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("request stalled without a held result");

  // reset empties the pipe
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind camera_perspective_projection cpp_checker u_cpp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire

[dv/camera_perspective_projection_test.sv]
// ----------------------------------------------------------------------------
// camera_perspective_projection_test
// drives points through the projection pipe under random idling on both
// sides, predicts every result and compares it field by field
// ----------------------------------------------------------------------------
module camera_perspective_projection_test;
  import cpp_pkg::*;

  localparam int SW = 400;
  localparam int SH = 400;
  localparam int N_RANDOM = 530;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 40;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  cpp_in_t in_data;
  logic out_valid;
  logic out_stall;
  cpp_out_t out_data;
  logic cfg_we;
  logic [2:0] cfg_index;
  logic [31:0] cfg_data;

  camera_perspective_projection #(
    .SCREEN_WIDTH (SW),
    .SCREEN_HEIGHT(SH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // camera pose as the predictor sees it
  longint cam_x, cam_y, cam_z;
  longint cos_yaw, sin_yaw, cos_pitch, sin_pitch;
  longint inv_fov;

  cpp_out_t projected_q[$];
  int  send_idle_pct;
  int  recv_idle_pct;
  int  fail_count;
  int  quiet_cycles;

  // directed rows: point, optional typed-in expectation
  typedef struct {
    cpp_in_t  pt;
    bit       has_exp;
    cpp_out_t exp;
  } point_row_t;

  point_row_t directed_rows[$];

  // clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic longint floor_q14(longint v);
    return (v + RND) >>> 14;
  endfunction

  // offset magnitude: trunc toward zero, clamped to 2^20
  function automatic longint pixel_shift(longint v, longint den);
    logic [127:0] num;
    logic [127:0] q;
    longint mag;
    mag = (v < 0) ? -v : v;
    num = 128'(mag) * 128'(SW) * 128'(65536);
    q = num / 128'(den);
    if (q > 128'(1 << 20)) q = 128'(1 << 20);
    return (v < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint clamp16(longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  function automatic cpp_out_t project_point(cpp_in_t pt);
    cpp_out_t r;
    longint dx, dy, dz, x1, z1, y2, z2, fov, den;
    dx = longint'(pt.point_x) - cam_x;
    dy = longint'(pt.point_y) - cam_y;
    dz = longint'(pt.point_z) - cam_z;
    x1 = floor_q14(dx * cos_yaw + dz * sin_yaw);
    z1 = floor_q14(dz * cos_yaw - dx * sin_yaw);
    y2 = floor_q14(dy * cos_pitch - z1 * sin_pitch);
    z2 = floor_q14(dy * sin_pitch + z1 * cos_pitch);
    r = '0;
    if (z2 <= 0) return r;
    fov = (inv_fov == 0) ? 1 : inv_fov;
    den = z2 * fov;
    r.visible = 1'b1;
    r.screen_x = 16'(clamp16(SW / 2 + pixel_shift(x1, den)));
    r.screen_y = 16'(clamp16(SH / 2 - pixel_shift(y2, den)));
    r.depth = (z2 > 64'h7FFF_FFFF) ? 31'h7FFF_FFFF : 31'(z2);
    r.attribute_out = pt.attribute;
    return r;
  endfunction

  function automatic void pose_reset();
    cam_x = 0;
    cam_y = 1966080;
    cam_z = -3932160;
    cos_yaw = 16384;
    sin_yaw = 0;
    cos_pitch = 14189;
    sin_pitch = -8192;
    inv_fov = 65536;
  endfunction

  // register write, only while the pipe is empty
  task automatic write_reg(cpp_cfg_idx_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_CAM_X:     cam_x = longint'($signed(val));
      CFG_CAM_Y:     cam_y = longint'($signed(val));
      CFG_CAM_Z:     cam_z = longint'($signed(val));
      CFG_COS_YAW:   cos_yaw = longint'($signed(val[15:0]));
      CFG_SIN_YAW:   sin_yaw = longint'($signed(val[15:0]));
      CFG_COS_PITCH: cos_pitch = longint'($signed(val[15:0]));
      CFG_SIN_PITCH: sin_pitch = longint'($signed(val[15:0]));
      CFG_INV_FOV:   inv_fov = longint'(val[23:0]);
      default: ;
    endcase
  endtask

  task automatic set_pose(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                          logic [15:0] cyw, logic [15:0] syw,
                          logic [15:0] cpt, logic [15:0] spt, logic [23:0] fov);
    write_reg(CFG_CAM_X, cx);
    write_reg(CFG_CAM_Y, cy);
    write_reg(CFG_CAM_Z, cz);
    write_reg(CFG_COS_YAW, {16'h0, cyw});
    write_reg(CFG_SIN_YAW, {16'h0, syw});
    write_reg(CFG_COS_PITCH, {16'h0, cpt});
    write_reg(CFG_SIN_PITCH, {16'h0, spt});
    write_reg(CFG_INV_FOV, {8'h0, fov});
  endtask

  // one request; the expectation is queued when the pipe accepts it
  // valid stays high afterwards so requests can follow back to back
  task automatic send_point(cpp_in_t pt, bit has_exp, cpp_out_t exp);
    cpp_out_t pred;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= pt;
    pred = project_point(pt);
    if (has_exp && pred !== exp) begin
      $error("table row disagrees with predictor: %h vs %h", exp, pred);
      fail_count++;
    end
    do @(posedge clk); while (in_stall);
    projected_q.insert(projected_q.size(), has_exp ? exp : pred);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (projected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly points in front of the camera, some anywhere in the word range
  function automatic cpp_in_t random_point();
    cpp_in_t pt;
    case ($urandom_range(9))
      0, 1: begin
        pt.point_x = $urandom();
        pt.point_y = $urandom();
        pt.point_z = $urandom();
      end
      2: begin
        pt.point_x = $signed($urandom_range(2000)) - 1000;
        pt.point_y = $signed($urandom_range(2000)) - 1000;
        pt.point_z = $signed($urandom_range(2000)) - 1000;
      end
      default: begin
        pt.point_x = ($signed($urandom_range(200)) - 100) <<< 16 | $urandom_range(65535);
        pt.point_y = ($signed($urandom_range(200)) - 100) <<< 16 | $urandom_range(65535);
        pt.point_z = ($signed($urandom_range(200)) - 60) <<< 16 | $urandom_range(65535);
      end
    endcase
    pt.attribute = $urandom();
    return pt;
  endfunction

  function automatic void add_row(logic [31:0] px, logic [31:0] py, logic [31:0] pz,
                                  logic [15:0] at, bit has_exp, cpp_out_t exp);
    point_row_t row;
    row.pt = '{point_x: px, point_y: py, point_z: pz, attribute: at};
    row.has_exp = has_exp;
    row.exp = exp;
    directed_rows.insert(directed_rows.size(), row);
  endfunction

  // result checker
  always @(posedge clk) begin
    cpp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (projected_q.size() == 0) begin
        $error("result with nothing expected: %h", out_data);
        fail_count++;
      end else begin
        want = projected_q.pop_front();
        if (out_data.visible !== want.visible) begin
          $error("visible: expected %0d, got %0d", want.visible, out_data.visible);
          fail_count++;
        end
        if (out_data.screen_x !== want.screen_x) begin
          $error("screen_x: expected %0d, got %0d", want.screen_x, out_data.screen_x);
          fail_count++;
        end
        if (out_data.screen_y !== want.screen_y) begin
          $error("screen_y: expected %0d, got %0d", want.screen_y, out_data.screen_y);
          fail_count++;
        end
        if (out_data.depth !== want.depth) begin
          $error("depth: expected %0d, got %0d", want.depth, out_data.depth);
          fail_count++;
        end
        if (out_data.attribute_out !== want.attribute_out) begin
          $error("attribute_out: expected %0d, got %0d", want.attribute_out,
                 out_data.attribute_out);
          fail_count++;
        end
      end
    end
  end

  // receiver idling, changed on the falling edge
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // watchdog on cycles without an accepted request or result, a register write or reset
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    cpp_out_t culled;
    cpp_out_t centre;
    cpp_in_t pt;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    out_stall = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    fail_count = 0;
    quiet_cycles = 0;
    pose_reset();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed part under the reset pose
    culled = '0;
    centre = '{visible: 1'b1, screen_x: 16'sd200, screen_y: 16'sd200,
               depth: 31'd0, attribute_out: 16'hFFFF};
    // point on the optical axis is hard to type in; the predictor covers those
    add_row(32'h0, 32'h001E_0000, 32'hFFC4_0000, 16'hFFFF, 1'b1, culled);  // camera itself
    add_row(32'h0, 32'h0, 32'h0, 16'h1234, 1'b0, centre);
    add_row(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF, 1'b0, centre);
    add_row(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'h0000, 1'b0, centre);
    add_row(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hA5A5, 1'b0, centre);
    add_row(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h5A5A, 1'b0, centre);
    add_row(32'h0, 32'h0, 32'hFF00_0000, 16'h0001, 1'b0, centre);  // far behind: culled
    add_row(32'h0001_0000, 32'h0, 32'h0, 16'h8000, 1'b0, centre);
    add_row(32'hFFFF_0000, 32'h0, 32'h0, 16'h7FFF, 1'b0, centre);
    add_row(32'h0, 32'h001E_0000, 32'hFFC4_0001, 16'h00FF, 1'b0, centre);  // tiny depth
    add_row(32'h0064_0000, 32'h0, 32'hFFC4_0001, 16'hFF00, 1'b0, centre);  // lands off screen
    add_row(32'hFF9C_0000, 32'h0064_0000, 32'hFFC4_0001, 16'h0F0F, 1'b0, centre);
    foreach (directed_rows[i])
      send_point(directed_rows[i].pt, directed_rows[i].has_exp, directed_rows[i].exp);
    wait_drain();

    // zero field of view, extreme rotations, far camera for depth saturation
    set_pose(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'h8000, 16'h7FFF,
             16'h7FFF, 16'h8000, 24'h0);
    for (int i = 0; i < 6; i++) send_point(random_point(), 1'b0, culled);
    wait_drain();
    set_pose(32'h0, 32'h0, 32'h8000_0000, 16'h4000, 16'h0, 16'h4000, 16'h0, 24'hFFFFFF);
    send_point('{point_x: 0, point_y: 0, point_z: 32'h7FFF_FFFF, attribute: 16'h3C3C},
               1'b0, culled);
    send_point('{point_x: 32'h7FFF_FFFF, point_y: 32'h8000_0000, point_z: 32'h7FFF_FFFF,
                 attribute: 16'hC3C3}, 1'b0, culled);
    wait_drain();

    // random part in three idling phases, pose changed between blocks
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 15 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 15 : 0;
      for (int blk = 0; blk < 3; blk++) begin
        if (blk == 0)
          set_pose(32'h0, 32'h001E_0000, 32'hFFC4_0000, 16'd16384, 16'd0,
                   16'd14189, 16'hE000, 24'd65536);
        else
          set_pose($urandom_range(1) ? $urandom() : ($signed($urandom_range(80)) - 40) <<< 16,
                   ($signed($urandom_range(80)) - 40) <<< 16,
                   ($signed($urandom_range(40)) - 80) <<< 16,
                   $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                   $urandom_range(32768) - 16384, $urandom_range(32768) - 16384,
                   $urandom_range(3) == 0 ? $urandom() : $urandom_range(40000, 200000));
        for (int i = 0; i < N_RANDOM / 9; i++) begin
          pt = random_point();
          send_point(pt, 1'b0, culled);
        end
        wait_drain();
      end
    end

    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
